// File: rtl/fnorm_pkg.sv
package fnorm_pkg;

  localparam int VERT_DEPTH = 4096;
  localparam int VERT_AW    = $clog2(VERT_DEPTH);
  localparam int IDX_W      = 12;
  localparam int POS_W      = 24;
  localparam int NRM_W      = 16;
  localparam int FQ_DEPTH   = 4;
  localparam int FQ_AW      = $clog2(FQ_DEPTH);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TRI  = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } vec_t;

  // one triangle with its three fetched vertex positions
  typedef struct packed {
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
    logic             last;
    vec_t             va;
    vec_t             vb;
    vec_t             vc;
  } tri_t;

  typedef struct packed {
    logic [62:0] s;
    logic [62:0] res;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        qb;
  } dv_t;

  // one digit of the bitwise integer square root
  function automatic sq_t sq_step(input sq_t st, input logic [62:0] b);
    sq_t o;
    logic [62:0] t;
    t = st.res + b;
    if (st.s >= t) begin
      o.s   = st.s - t;
      o.res = (st.res >> 1) + b;
    end else begin
      o.s   = st.s;
      o.res = st.res >> 1;
    end
    return o;
  endfunction

  // one quotient bit of restoring division; rem stays below twice the divisor
  function automatic dv_t div_step(input logic [31:0] rem, input logic [30:0] d);
    dv_t o;
    logic [31:0] r2;
    o.qb  = (rem >= {1'b0, d});
    r2    = o.qb ? rem - {1'b0, d} : rem;
    o.rem = {r2[30:0], 1'b0};
    return o;
  endfunction

endpackage

// File: rtl/face_normal_generator.sv
// channel   direction  handshake                 beat
// input     in         push / full               op, index_a..c, pos_x..z, last_in
// result    out        empty / pop               out_index_a..c, normal_x..z, last_out
// config    in         cfg_we                    cfg_wdata (normals_enabled)
//
// A load does not set busy; a triangle holds the input side for one read per
// vertex of the single-port vertex memory.
// The normalize unit takes one triangle at a time through shift search, square root
// and divide (a zero cross product skips all three), and sets the sustained
// triangle rate; a result not yet popped holds it in its output state.
// A four-entry queue between fetch and normalize lets each side stall alone.
// rst is synchronous; the vertex memory is not cleared.
module face_normal_generator
  import fnorm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    op,
  input  logic [IDX_W-1:0]        index_a,
  input  logic [IDX_W-1:0]        index_b,
  input  logic [IDX_W-1:0]        index_c,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic                    last_in,
  output logic                    empty,
  input  logic                    pop,
  output logic [IDX_W-1:0]        out_index_a,
  output logic [IDX_W-1:0]        out_index_b,
  output logic [IDX_W-1:0]        out_index_c,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    last_out,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata
);

  logic           normals_enabled;
  logic           fq_wr;
  logic           fq_rd;
  logic           fq_empty;
  logic [FQ_AW:0] fq_level;
  tri_t           fq_wdata;
  tri_t           fq_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      normals_enabled <= 1'b1;
    end else if (cfg_we) begin
      normals_enabled <= cfg_wdata;
    end
  end

  fnorm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .op              (op),
    .index_a         (index_a),
    .index_b         (index_b),
    .index_c         (index_c),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .last_in         (last_in),
    .normals_enabled (normals_enabled),
    .fq_level        (fq_level),
    .fq_wr           (fq_wr),
    .fq_wdata        (fq_wdata)
  );

  fnorm_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (fq_wr),
    .wdata (fq_wdata),
    .rd    (fq_rd),
    .rdata (fq_rdata),
    .empty (fq_empty),
    .level (fq_level)
  );

  fnorm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .fq_empty    (fq_empty),
    .fq_rdata    (fq_rdata),
    .fq_rd       (fq_rd),
    .empty       (empty),
    .pop         (pop),
    .out_index_a (out_index_a),
    .out_index_b (out_index_b),
    .out_index_c (out_index_c),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .last_out    (last_out)
  );

endmodule

// File: rtl/fnorm_fifo.sv
module fnorm_fifo
  import fnorm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  tri_t            wdata,
  input  logic            rd,
  output tri_t            rdata,
  output logic            empty,
  output logic [FQ_AW:0]  level
);

  tri_t             slots [FQ_DEPTH];
  logic [FQ_AW-1:0] wp;
  logic [FQ_AW-1:0] rp;

  assign empty = (level == '0);
  assign rdata = slots[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      if (wr && !rd) begin
        level <= level + 1'b1;
      end else if (rd && !wr) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// File: rtl/fnorm_front.sv
module fnorm_front
  import fnorm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    op,
  input  logic [IDX_W-1:0]        index_a,
  input  logic [IDX_W-1:0]        index_b,
  input  logic [IDX_W-1:0]        index_c,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic                    last_in,
  input  logic                    normals_enabled,
  input  logic [FQ_AW:0]          fq_level,
  output logic                    fq_wr,
  output tri_t                    fq_wdata
);

  localparam logic [FQ_AW:0] FQ_LIMIT = (FQ_AW+1)'(FQ_DEPTH - 2);

  logic [3*POS_W-1:0] mem [VERT_DEPTH];
  logic [3*POS_W-1:0] rd_q;
  logic [VERT_AW-1:0] addr;
  logic               acc;
  logic               we;
  logic               busy;
  logic               phase;
  logic               fin;
  logic               keep;
  logic [IDX_W-1:0]   ia;
  logic [IDX_W-1:0]   ib;
  logic [IDX_W-1:0]   ic;
  logic               last;
  vec_t               va;
  vec_t               vb;

  // two in flight at most: one finishing, one just taken
  assign full = busy || (fq_level >= FQ_LIMIT);
  assign acc  = push && !full;
  assign we   = acc && (op == OP_LOAD);

  // vertex a is read at the accept edge, then b and c in the busy phases that follow
  always_comb begin
    if (busy) begin
      addr = phase ? ic[VERT_AW-1:0] : ib[VERT_AW-1:0];
    end else begin
      addr = index_a[VERT_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= {pos_x, pos_y, pos_z};
    end else begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      fin   <= 1'b0;
    end else begin
      fin <= busy && phase && keep;
      if (acc && (op == OP_TRI)) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (busy) begin
        busy  <= !phase;
        phase <= !phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (op == OP_TRI)) begin
      ia   <= index_a;
      ib   <= index_b;
      ic   <= index_c;
      last <= last_in;
      keep <= normals_enabled;
    end
    if (busy && !phase) begin
      va <= vec_t'(rd_q);
    end
    if (busy && phase) begin
      vb <= vec_t'(rd_q);
    end
  end

  assign fq_wr          = fin;
  assign fq_wdata.ia    = ia;
  assign fq_wdata.ib    = ib;
  assign fq_wdata.ic    = ic;
  assign fq_wdata.last  = last;
  assign fq_wdata.va    = va;
  assign fq_wdata.vb    = vb;
  assign fq_wdata.vc    = vec_t'(rd_q);

endmodule

// File: rtl/fnorm_back.sv
module fnorm_back
  import fnorm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fq_empty,
  input  tri_t                    fq_rdata,
  output logic                    fq_rd,
  output logic                    empty,
  input  logic                    pop,
  output logic [IDX_W-1:0]        out_index_a,
  output logic [IDX_W-1:0]        out_index_b,
  output logic [IDX_W-1:0]        out_index_c,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    last_out
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_CROSS = 4'd2;
  localparam logic [3:0] ST_MAG   = 4'd3;
  localparam logic [3:0] ST_SHIFT = 4'd4;
  localparam logic [3:0] ST_SQR   = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic [3:0]  SQRT_LAST = 4'd15;
  localparam logic [3:0]  DIV_LAST  = 4'd4;
  localparam logic [14:0] Q_MAX     = 15'd16384;

  logic [3:0]  state;
  logic [3:0]  cnt;
  logic        out_valid;
  logic        out_free;

  logic [IDX_W-1:0] ia, ib, ic;
  logic             last;

  logic signed [POS_W:0]     ab [3];
  logic signed [POS_W:0]     ac [3];
  logic signed [2*POS_W+1:0] p  [6];
  logic signed [2*POS_W+2:0] c  [3];
  logic [2*POS_W+2:0]        a  [3];
  logic                      neg [3];
  logic                      zero;
  logic [59:0]               sq [3];
  logic [62:0]               s_r, res_r, bit_r;
  logic [31:0]               rem [3];
  logic [14:0]               q   [3];

  logic              hi8, hi1;
  logic [30:0]       dvs;
  sq_t               sq1, sq2;
  logic [31:0]       rem_nx [3];
  logic [14:0]       q_nx   [3];
  logic [14:0]       qs     [3];
  logic [NRM_W-1:0]  nrm    [3];

  assign empty    = !out_valid;
  // the output register frees up on the edge that pops it
  assign out_free = !out_valid || pop;
  assign fq_rd    = (state == ST_IDLE) && !fq_empty;

  assign hi8 = (|a[0][2*POS_W+2:38]) || (|a[1][2*POS_W+2:38]) || (|a[2][2*POS_W+2:38]);
  assign hi1 = (|a[0][2*POS_W+2:30]) || (|a[1][2*POS_W+2:30]) || (|a[2][2*POS_W+2:30]);
  assign dvs = (res_r[30:0] == '0) ? 31'd1 : res_r[30:0];

  always_comb begin
    dv_t d;
    sq1 = sq_step('{s: s_r, res: res_r}, bit_r);
    sq2 = sq_step(sq1, bit_r >> 2);
    for (int i = 0; i < 3; i++) begin
      d         = div_step(rem[i], dvs);
      q_nx[i]   = {q[i][13:0], d.qb};
      d         = div_step(d.rem, dvs);
      q_nx[i]   = {q_nx[i][13:0], d.qb};
      d         = div_step(d.rem, dvs);
      q_nx[i]   = {q_nx[i][13:0], d.qb};
      rem_nx[i] = d.rem;
      qs[i]     = (q[i] > Q_MAX) ? Q_MAX : q[i];
      nrm[i]    = neg[i] ? -{1'b0, qs[i]} : {1'b0, qs[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (fq_rd) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:   state <= ST_CROSS;
        ST_CROSS: state <= ST_MAG;
        ST_MAG: begin
          state <= (c[0] == '0 && c[1] == '0 && c[2] == '0) ? ST_OUT : ST_SHIFT;
        end
        ST_SHIFT: begin
          if (!hi1) begin
            state <= ST_SQR;
          end
        end
        ST_SQR: state <= ST_SUM;
        ST_SUM: begin
          state <= ST_SQRT;
          cnt   <= '0;
        end
        ST_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == SQRT_LAST) begin
            state <= ST_DIV;
            cnt   <= '0;
          end
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        ia      <= fq_rdata.ia;
        ib      <= fq_rdata.ib;
        ic      <= fq_rdata.ic;
        last    <= fq_rdata.last;
        ab[0]   <= {fq_rdata.vb.x[POS_W-1], fq_rdata.vb.x} - {fq_rdata.va.x[POS_W-1], fq_rdata.va.x};
        ab[1]   <= {fq_rdata.vb.y[POS_W-1], fq_rdata.vb.y} - {fq_rdata.va.y[POS_W-1], fq_rdata.va.y};
        ab[2]   <= {fq_rdata.vb.z[POS_W-1], fq_rdata.vb.z} - {fq_rdata.va.z[POS_W-1], fq_rdata.va.z};
        ac[0]   <= {fq_rdata.vc.x[POS_W-1], fq_rdata.vc.x} - {fq_rdata.va.x[POS_W-1], fq_rdata.va.x};
        ac[1]   <= {fq_rdata.vc.y[POS_W-1], fq_rdata.vc.y} - {fq_rdata.va.y[POS_W-1], fq_rdata.va.y};
        ac[2]   <= {fq_rdata.vc.z[POS_W-1], fq_rdata.vc.z} - {fq_rdata.va.z[POS_W-1], fq_rdata.va.z};
      end
      ST_MUL: begin
        p[0] <= ab[1] * ac[2];
        p[1] <= ab[2] * ac[1];
        p[2] <= ab[2] * ac[0];
        p[3] <= ab[0] * ac[2];
        p[4] <= ab[0] * ac[1];
        p[5] <= ab[1] * ac[0];
      end
      ST_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          c[i] <= {p[2*i][2*POS_W+1], p[2*i]} - {p[2*i+1][2*POS_W+1], p[2*i+1]};
        end
      end
      ST_MAG: begin
        zero <= (c[0] == '0 && c[1] == '0 && c[2] == '0);
        for (int i = 0; i < 3; i++) begin
          neg[i] <= c[i][2*POS_W+2];
          a[i]   <= c[i][2*POS_W+2] ? -c[i] : c[i];
        end
      end
      ST_SHIFT: begin
        // coarse step of eight, then single steps, until all fit in 30 bits
        for (int i = 0; i < 3; i++) begin
          if (hi8) begin
            a[i] <= a[i] >> 8;
          end else if (hi1) begin
            a[i] <= a[i] >> 1;
          end
        end
      end
      ST_SQR: begin
        for (int i = 0; i < 3; i++) begin
          sq[i] <= a[i][29:0] * a[i][29:0];
        end
      end
      ST_SUM: begin
        s_r   <= {3'b0, sq[0]} + {3'b0, sq[1]} + {3'b0, sq[2]};
        res_r <= '0;
        bit_r <= 63'(1) << 62;
        for (int i = 0; i < 3; i++) begin
          rem[i] <= {2'b0, a[i][29:0]};
          q[i]   <= '0;
        end
      end
      ST_SQRT: begin
        s_r   <= sq2.s;
        res_r <= sq2.res;
        bit_r <= bit_r >> 4;
      end
      ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          rem[i] <= rem_nx[i];
          q[i]   <= q_nx[i];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_index_a <= ia;
          out_index_b <= ib;
          out_index_c <= ic;
          last_out    <= last;
          normal_x    <= zero ? '0 : nrm[0];
          normal_y    <= zero ? '0 : nrm[1];
          normal_z    <= zero ? '0 : nrm[2];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/fnorm_chk.sv
module fnorm_chk
  import fnorm_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    full,
  input logic                    empty,
  input logic                    pop,
  input logic [IDX_W-1:0]        out_index_a,
  input logic signed [NRM_W-1:0] normal_x,
  input logic signed [NRM_W-1:0] normal_y,
  input logic signed [NRM_W-1:0] normal_z
);

  localparam logic signed [NRM_W-1:0] N_MAX = 16'sd16384;
  localparam logic signed [NRM_W-1:0] N_MIN = -16'sd16384;

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(normal_x) && $stable(out_index_a))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> normal_x <= N_MAX && normal_x >= N_MIN && normal_y <= N_MAX &&
               normal_y >= N_MIN && normal_z <= N_MAX && normal_z >= N_MIN)
    else $error("normal component out of Q1.14 range");

  a_reset: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("not idle after reset");

endmodule

bind face_normal_generator fnorm_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_index_a (out_index_a),
  .normal_x    (normal_x),
  .normal_y    (normal_y),
  .normal_z    (normal_z)
);
